FILE: rtl/mrs_pkg.sv
package mrs_pkg;

  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h10;
  localparam int STORE_DEPTH = 41;
  localparam int HEADER_LEN  = 6;
  localparam int HDR_REGS    = 7;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;
  localparam logic [15:0] SILENCE_RESET = 16'd1000;

  localparam logic [1:0] ACT_BYTE   = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_LWRITE = 2'd2;
  localparam logic [1:0] ACT_LREAD  = 2'd3;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_LREAD  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_CRC = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  localparam logic [1:0] MARK_NONE    = 2'd0;
  localparam logic [1:0] MARK_WRITTEN = 2'd1;
  localparam logic [1:0] MARK_READ    = 2'd2;

  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_SILENCE    = 1'b1;

  typedef enum logic [3:0] {
    TX_SA, TX_FN, TX_AH, TX_AL, TX_CH, TX_CL, TX_BC, TX_RH, TX_RL, TX_CRCL, TX_CRCH
  } tx_sel_t;

  typedef enum logic [1:0] {SRC_STATUS, SRC_TX, SRC_LREAD} emit_src_t;

  typedef struct packed {
    logic      latch;
    logic      take_byte;
    logic      clear_silence;
    logic      set_length;
    logic      set_oversize;
    logic      clr_oversize;
    logic      restart;
    logic      tick_count;
    logic      lwrite;
    logic      emit;
    emit_src_t src;
    logic [2:0] status;
    tx_sel_t   sel;
    logic      last;
    logic      idx_clr;
    logic      idx_inc;
    logic      mark_read;
    logic      lread_clr;
    logic      mem_lo;
    logic      hold_cap;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic oversize;
    logic hdr6_write;
    logic cnt_over;
    logic finish_due;
    logic crc_bad;
    logic addr_bad;
    logic range_bad;
    logic fn_write;
    logic loop_end;
    logic tick_noop;
    logic silence_hit;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

FILE: rtl/modbus_rtu_register_slave_core.sv
// Modbus RTU slave core with a small holding-register file.
// Input channel (in_valid/in_stall) carries one word per event: a received
// bus byte, a silence tick, or a local register write or read.
// Output channel (out_valid/out_stall) carries result words: transmit bytes,
// frame status and local read data; last marks the final word of an event.
// A good frame emits its status and response at one word per cycle from the
// output register while the receiver does not stall; a write frame pauses
// its response to commit each register, reading the two data bytes of that
// register through the single read port of the frame store.
// One event is handled at a time; in_stall is high while an event is busy.
// When the receiver stalls, the held word stays put and the sequencer waits.
// Reset (rst, synchronous) clears the frame state, registers and marks, and
// loads slave address 0 and silence limit 1000; there is no clearing pass.
// Configuration writes (cfg_write) are applied at once and must come while idle.
module modbus_rtu_register_slave_core #(
  parameter int REG_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  input  logic [3:0]  reg_index,
  input  logic [15:0] reg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [2:0]  frame_status,
  output logic [15:0] read_value,
  output logic [1:0]  change_mark,
  output logic        last
);

  mrs_pkg::cmd_t  cmd;
  mrs_pkg::stat_t stat;
  logic           in_ready;

  assign in_stall = rst || !in_ready;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid && !rst),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mrs_dp #(.REG_COUNT(REG_COUNT)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .rx_byte      (rx_byte),
    .reg_index    (reg_index),
    .reg_value    (reg_value),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .kind         (kind),
    .tx_byte      (tx_byte),
    .frame_status (frame_status),
    .read_value   (read_value),
    .change_mark  (change_mark),
    .last         (last)
  );

endmodule

FILE: rtl/mrs_ctrl.sv
module mrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mrs_pkg::stat_t stat,
  output logic           in_ready,
  output mrs_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_BCHK, S_FIN, S_TX_SA, S_TX_FN, S_CM_HI, S_CM_LO, S_CM_WR,
    S_TX_AH, S_TX_AL, S_TX_CH, S_TX_CL, S_TX_BC, S_RD_HI, S_RD_LO, S_TX_CRCL, S_TX_CRCH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
          unique case (stat.act)
            mrs_pkg::ACT_BYTE: begin
              if (stat.oversize) cmd.clear_silence = 1'b1;
              else begin
                cmd.take_byte = 1'b1;
                state_next = S_BCHK;
              end
            end
            mrs_pkg::ACT_TICK: begin
              if (!stat.tick_noop) begin
                cmd.tick_count = 1'b1;
                if (stat.silence_hit) begin
                  cmd.restart = 1'b1;
                  if (stat.oversize) cmd.clr_oversize = 1'b1;
                  else begin
                    cmd.emit = 1'b1;
                    cmd.src = mrs_pkg::SRC_STATUS;
                    cmd.status = mrs_pkg::ST_TIMEOUT;
                    cmd.last = 1'b1;
                  end
                end
              end
            end
            mrs_pkg::ACT_LWRITE: cmd.lwrite = 1'b1;
            default: begin
              cmd.emit = 1'b1;
              cmd.src = mrs_pkg::SRC_LREAD;
              cmd.last = 1'b1;
              cmd.lread_clr = 1'b1;
            end
          endcase
        end
      end
      S_BCHK: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
          if (stat.hdr6_write) begin
            if (stat.cnt_over) begin
              cmd.emit = 1'b1;
              cmd.src = mrs_pkg::SRC_STATUS;
              cmd.status = mrs_pkg::ST_RANGE;
              cmd.last = 1'b1;
              cmd.restart = 1'b1;
              cmd.set_oversize = 1'b1;
            end else cmd.set_length = 1'b1;
          end else if (stat.finish_due) state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.restart = 1'b1;
          cmd.emit = 1'b1;
          cmd.src = mrs_pkg::SRC_STATUS;
          cmd.last = 1'b1;
          state_next = S_IDLE;
          if (stat.crc_bad) cmd.status = mrs_pkg::ST_BAD_CRC;
          else if (stat.addr_bad) cmd.status = mrs_pkg::ST_OTHER;
          else if (stat.range_bad) cmd.status = mrs_pkg::ST_RANGE;
          else begin
            cmd.status = mrs_pkg::ST_OK;
            cmd.last = 1'b0;
            cmd.idx_clr = 1'b1;
            state_next = S_TX_SA;
          end
        end
      end
      S_CM_HI: state_next = S_CM_LO;
      S_CM_LO: begin
        cmd.mem_lo = 1'b1;
        cmd.hold_cap = 1'b1;
        state_next = S_CM_WR;
      end
      S_CM_WR: begin
        cmd.commit = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = stat.loop_end ? S_TX_AH : S_CM_HI;
      end
      default: begin
        // response byte states, one word each
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src = mrs_pkg::SRC_TX;
          unique case (state)
            S_TX_SA: begin cmd.sel = mrs_pkg::TX_SA; state_next = S_TX_FN; end
            S_TX_FN: begin
              cmd.sel = mrs_pkg::TX_FN;
              state_next = stat.fn_write ? S_CM_HI : S_TX_BC;
            end
            S_TX_AH: begin cmd.sel = mrs_pkg::TX_AH; state_next = S_TX_AL; end
            S_TX_AL: begin cmd.sel = mrs_pkg::TX_AL; state_next = S_TX_CH; end
            S_TX_CH: begin cmd.sel = mrs_pkg::TX_CH; state_next = S_TX_CL; end
            S_TX_CL: begin cmd.sel = mrs_pkg::TX_CL; state_next = S_TX_CRCL; end
            S_TX_BC: begin cmd.sel = mrs_pkg::TX_BC; state_next = S_RD_HI; end
            S_RD_HI: begin cmd.sel = mrs_pkg::TX_RH; state_next = S_RD_LO; end
            S_RD_LO: begin
              cmd.sel = mrs_pkg::TX_RL;
              cmd.mark_read = 1'b1;
              cmd.idx_inc = 1'b1;
              state_next = stat.loop_end ? S_TX_CRCL : S_RD_HI;
            end
            S_TX_CRCL: begin cmd.sel = mrs_pkg::TX_CRCL; state_next = S_TX_CRCH; end
            default: begin
              cmd.sel = mrs_pkg::TX_CRCH;
              cmd.last = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

FILE: rtl/mrs_dp.sv
module mrs_dp #(
  parameter int REG_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [1:0]    action,
  input  logic [7:0]    rx_byte,
  input  logic [3:0]    reg_index,
  input  logic [15:0]   reg_value,
  input  logic          out_stall,
  input  mrs_pkg::cmd_t cmd,
  output mrs_pkg::stat_t stat,
  output logic          out_valid,
  output logic [1:0]    kind,
  output logic [7:0]    tx_byte,
  output logic [2:0]    frame_status,
  output logic [15:0]   read_value,
  output logic [1:0]    change_mark,
  output logic          last
);

  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]  slave_addr;
  logic [15:0] silence_limit;
  logic [1:0]  in_act;
  logic [7:0]  in_byte;
  logic [3:0]  in_idx;
  logic [15:0] in_val;
  logic [7:0]  hdr [mrs_pkg::HDR_REGS];
  logic [7:0]  mem [mrs_pkg::STORE_DEPTH];
  logic [7:0]  mem_rd;
  logic [5:0]  mem_addr;
  logic [5:0]  count;
  logic [5:0]  flen;
  logic [15:0] rcrc;
  logic [15:0] silence;
  logic [15:0] silence_next;
  logic        oversize;
  logic [15:0] regs [REG_COUNT];
  logic [1:0]  marks [REG_COUNT];
  logic [4:0]  idx;
  logic [7:0]  hold;
  logic [15:0] txcrc;
  logic [7:0]  txb;
  logic [15:0] rcnt;
  logic [15:0] raddr;
  logic [3:0]  ptr;
  logic        idx_ok;

  assign raddr = {hdr[2], hdr[3]};
  assign rcnt  = {hdr[4], hdr[5]};
  assign ptr   = raddr[3:0] + idx[3:0];
  assign idx_ok = (in_idx < REG_COUNT);
  assign silence_next = (silence == mrs_pkg::SILENCE_MAX) ? silence : silence + 16'd1;
  assign mem_addr = 6'd7 + {idx, 1'b0} + {5'd0, cmd.mem_lo};

  always_comb begin
    stat.act = in_act;
    stat.oversize = oversize;
    stat.hdr6_write = (count == 6'(mrs_pkg::HEADER_LEN)) && (hdr[1] == mrs_pkg::FN_WRITE);
    stat.cnt_over = (rcnt > REG_COUNT);
    stat.finish_due = (count >= flen);
    stat.crc_bad = (rcrc != 16'h0000);
    stat.addr_bad = (hdr[0] != slave_addr);
    stat.range_bad = ((hdr[1] != mrs_pkg::FN_READ) && (hdr[1] != mrs_pkg::FN_WRITE))
                     || (rcnt == 16'h0000)
                     || (({1'b0, raddr} + {1'b0, rcnt}) > REG_COUNT)
                     || ((hdr[1] == mrs_pkg::FN_WRITE) && ({9'd0, hdr[6]} != {rcnt, 1'b0}));
    stat.fn_write = (hdr[1] == mrs_pkg::FN_WRITE);
    stat.loop_end = (({11'd0, idx} + 16'd1) == rcnt);
    stat.tick_noop = !oversize && (count == 6'd0);
    stat.silence_hit = (silence_next >= silence_limit);
    stat.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    case (cmd.sel)
      mrs_pkg::TX_SA:   txb = slave_addr;
      mrs_pkg::TX_FN:   txb = hdr[1];
      mrs_pkg::TX_AH:   txb = hdr[2];
      mrs_pkg::TX_AL:   txb = hdr[3];
      mrs_pkg::TX_CH:   txb = hdr[4];
      mrs_pkg::TX_CL:   txb = hdr[5];
      mrs_pkg::TX_BC:   txb = {rcnt[6:0], 1'b0};
      mrs_pkg::TX_RH:   txb = regs[ptr[RW-1:0]][15:8];
      mrs_pkg::TX_RL:   txb = regs[ptr[RW-1:0]][7:0];
      mrs_pkg::TX_CRCL: txb = txcrc[7:0];
      mrs_pkg::TX_CRCH: txb = txcrc[15:8];
      default:          txb = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr <= 8'h00;
      silence_limit <= mrs_pkg::SILENCE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == mrs_pkg::CFG_SLAVE_ADDR) slave_addr <= cfg_data[7:0];
      else silence_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_act <= action;
      in_byte <= rx_byte;
      in_idx <= reg_index;
      in_val <= reg_value;
    end
  end

  // frame store, header bytes also kept in flops for the checks
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (count < 6'(mrs_pkg::STORE_DEPTH)) mem[count] <= in_byte;
      if (count < 6'(mrs_pkg::HDR_REGS)) hdr[count[2:0]] <= in_byte;
    end
    mem_rd <= mem[mem_addr];
    if (cmd.hold_cap) hold <= mem_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 6'd0;
      flen <= 6'd8;
      rcrc <= mrs_pkg::CRC_INIT;
      silence <= 16'h0000;
      oversize <= 1'b0;
    end else begin
      if (cmd.take_byte) begin
        count <= count + 6'd1;
        rcrc <= mrs_pkg::crc_add(rcrc, in_byte);
      end
      if (cmd.take_byte || cmd.clear_silence) silence <= 16'h0000;
      else if (cmd.tick_count) silence <= silence_next;
      if (cmd.set_length) flen <= 6'd9 + {rcnt[4:0], 1'b0};
      if (cmd.set_oversize) oversize <= 1'b1;
      else if (cmd.clr_oversize) oversize <= 1'b0;
      if (cmd.restart) begin
        count <= 6'd0;
        flen <= 6'd8;
        rcrc <= mrs_pkg::CRC_INIT;
        silence <= 16'h0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) idx <= 5'd0;
    else if (cmd.idx_inc) idx <= idx + 5'd1;
    if (cmd.restart) txcrc <= mrs_pkg::CRC_INIT;
    else if (cmd.emit && cmd.src == mrs_pkg::SRC_TX && cmd.sel != mrs_pkg::TX_CRCL
             && cmd.sel != mrs_pkg::TX_CRCH)
      txcrc <= mrs_pkg::crc_add(txcrc, txb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < REG_COUNT; r++) begin
        regs[r] <= 16'h0000;
        marks[r] <= mrs_pkg::MARK_NONE;
      end
    end else begin
      if (cmd.commit) begin
        regs[ptr[RW-1:0]] <= {hold, mem_rd};
        marks[ptr[RW-1:0]] <= mrs_pkg::MARK_WRITTEN;
      end else if (cmd.lwrite && idx_ok) begin
        regs[in_idx[RW-1:0]] <= in_val;
      end
      if (cmd.mark_read) marks[ptr[RW-1:0]] <= mrs_pkg::MARK_READ;
      else if (cmd.lread_clr && idx_ok) marks[in_idx[RW-1:0]] <= mrs_pkg::MARK_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tx_byte <= 8'h00;
      frame_status <= mrs_pkg::ST_OK;
      read_value <= 16'h0000;
      change_mark <= mrs_pkg::MARK_NONE;
      last <= cmd.last;
      case (cmd.src)
        mrs_pkg::SRC_TX: begin
          kind <= mrs_pkg::KIND_TX;
          tx_byte <= txb;
        end
        mrs_pkg::SRC_LREAD: begin
          kind <= mrs_pkg::KIND_LREAD;
          if (idx_ok) begin
            read_value <= regs[in_idx[RW-1:0]];
            change_mark <= marks[in_idx[RW-1:0]];
          end
        end
        default: begin
          kind <= mrs_pkg::KIND_STATUS;
          frame_status <= cmd.status;
        end
      endcase
    end
  end

endmodule

FILE: rtl/mrs_checker.sv
module mrs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [2:0] frame_status,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before event handled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mrs_pkg::KIND_STATUS && frame_status != mrs_pkg::ST_OK |-> last)
    else $error("error status not final word");

  a_lread_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mrs_pkg::KIND_LREAD |-> last)
    else $error("local read data not final word");

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modbus_rtu_register_slave_core mrs_checker u_mrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .frame_status (frame_status),
  .last         (last)
);

FILE: tb/modbus_rtu_register_slave_core_tb.sv
module modbus_rtu_register_slave_core_tb;

  localparam int NREG = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [2:0]  frame_status;
    logic [15:0] read_value;
    logic [1:0]  change_mark;
    logic        last;
  } slave_word_t;

  class slave_scoreboard;
    logic [7:0]  addr_cfg;
    logic [15:0] silence_cfg;
    logic [7:0]  frame_bytes [mrs_pkg::STORE_DEPTH];
    int          nbytes;
    int          flen;
    logic [15:0] crc_acc;
    logic [15:0] quiet;
    bit          dropping;
    logic [15:0] regs [NREG];
    logic [1:0]  marks [NREG];
    slave_word_t pending [$];
    slave_word_t burst [$];
    int          errors;

    function void init();
      addr_cfg = 8'd0;
      silence_cfg = mrs_pkg::SILENCE_RESET;
      restart();
      dropping = 0;
      errors = 0;
      for (int i = 0; i < NREG; i++) begin
        regs[i] = '0;
        marks[i] = mrs_pkg::MARK_NONE;
      end
    endfunction

    function void restart();
      nbytes = 0;
      flen = 8;
      crc_acc = mrs_pkg::CRC_INIT;
      quiet = '0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
    endfunction

    function void emit(logic [1:0] k, logic [7:0] t, logic [2:0] s, logic [15:0] v,
                       logic [1:0] m);
      slave_word_t w;
      w.kind = k; w.tx_byte = t; w.frame_status = s; w.read_value = v;
      w.change_mark = m; w.last = 0;
      burst.push_back(w);
    endfunction

    function void send_byte(logic [7:0] b, inout logic [15:0] c);
      emit(mrs_pkg::KIND_TX, b, mrs_pkg::ST_OK, 0, mrs_pkg::MARK_NONE);
      c = crc_step(c, b);
    endfunction

    function void close_frame();
      logic [7:0] fn;
      int start, cnt;
      logic [15:0] c;
      fn = frame_bytes[1];
      start = {frame_bytes[2], frame_bytes[3]};
      cnt = {frame_bytes[4], frame_bytes[5]};
      c = mrs_pkg::CRC_INIT;
      if (crc_acc != 0) begin
        emit(mrs_pkg::KIND_STATUS, 0, mrs_pkg::ST_BAD_CRC, 0, mrs_pkg::MARK_NONE);
        return;
      end
      if (frame_bytes[0] != addr_cfg) begin
        emit(mrs_pkg::KIND_STATUS, 0, mrs_pkg::ST_OTHER, 0, mrs_pkg::MARK_NONE);
        return;
      end
      if ((fn != mrs_pkg::FN_READ && fn != mrs_pkg::FN_WRITE) || cnt == 0 ||
          start + cnt > NREG ||
          (fn == mrs_pkg::FN_WRITE && frame_bytes[6] != 2 * cnt)) begin
        emit(mrs_pkg::KIND_STATUS, 0, mrs_pkg::ST_RANGE, 0, mrs_pkg::MARK_NONE);
        return;
      end
      emit(mrs_pkg::KIND_STATUS, 0, mrs_pkg::ST_OK, 0, mrs_pkg::MARK_NONE);
      send_byte(addr_cfg, c);
      send_byte(fn, c);
      if (fn == mrs_pkg::FN_WRITE) begin
        for (int i = 0; i < cnt; i++) begin
          regs[start + i] = {frame_bytes[7 + 2 * i], frame_bytes[8 + 2 * i]};
          marks[start + i] = mrs_pkg::MARK_WRITTEN;
        end
        for (int i = 2; i < 6; i++) send_byte(frame_bytes[i], c);
      end else begin
        send_byte(8'(2 * cnt), c);
        for (int i = 0; i < cnt; i++) begin
          marks[start + i] = mrs_pkg::MARK_READ;
          send_byte(regs[start + i][15:8], c);
          send_byte(regs[start + i][7:0], c);
        end
      end
      emit(mrs_pkg::KIND_TX, c[7:0], mrs_pkg::ST_OK, 0, mrs_pkg::MARK_NONE);
      emit(mrs_pkg::KIND_TX, c[15:8], mrs_pkg::ST_OK, 0, mrs_pkg::MARK_NONE);
    endfunction

    // note one accepted input word and queue what it should produce
    function void note_input(logic [1:0] act, logic [7:0] b, logic [3:0] idx,
                             logic [15:0] val);
      int cnt;
      burst.delete();
      case (act)
        mrs_pkg::ACT_BYTE: begin
          quiet = '0;
          if (!dropping) begin
            if (nbytes < mrs_pkg::STORE_DEPTH) frame_bytes[nbytes] = b;
            nbytes++;
            crc_acc = crc_step(crc_acc, b);
            cnt = {frame_bytes[4], frame_bytes[5]};
            if (nbytes == mrs_pkg::HEADER_LEN && frame_bytes[1] == mrs_pkg::FN_WRITE &&
                cnt > NREG) begin
              emit(mrs_pkg::KIND_STATUS, 0, mrs_pkg::ST_RANGE, 0, mrs_pkg::MARK_NONE);
              restart();
              dropping = 1;
            end else begin
              if (nbytes == mrs_pkg::HEADER_LEN && frame_bytes[1] == mrs_pkg::FN_WRITE)
                flen = 9 + 2 * cnt;
              if (nbytes >= flen) begin
                close_frame();
                restart();
              end
            end
          end
        end
        mrs_pkg::ACT_TICK: begin
          if (dropping || nbytes != 0) begin
            if (quiet != 16'hFFFF) quiet++;
            if (quiet >= silence_cfg) begin
              if (dropping) dropping = 0;
              else emit(mrs_pkg::KIND_STATUS, 0, mrs_pkg::ST_TIMEOUT, 0, mrs_pkg::MARK_NONE);
              restart();
            end
          end
        end
        mrs_pkg::ACT_LWRITE: regs[idx] = val;
        default: begin
          emit(mrs_pkg::KIND_LREAD, 0, mrs_pkg::ST_OK, regs[idx], marks[idx]);
          marks[idx] = mrs_pkg::MARK_NONE;
        end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    function void check_result(slave_word_t got);
      slave_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch expected kind=%0d tx=%h st=%0d rv=%h mk=%0d last=%0d",
                 $time, exp_w.kind, exp_w.tx_byte, exp_w.frame_status, exp_w.read_value,
                 exp_w.change_mark, exp_w.last);
        $display("%0t:          actual   kind=%0d tx=%h st=%0d rv=%h mk=%0d last=%0d",
                 $time, got.kind, got.tx_byte, got.frame_status, got.read_value,
                 got.change_mark, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0, cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  logic [1:0] action = 0;
  logic [7:0] rx_byte = 0;
  logic [3:0] reg_index = 0;
  logic [15:0] reg_value = 0;
  logic out_valid, out_stall = 0;
  logic [1:0] kind, change_mark;
  logic [7:0] tx_byte;
  logic [2:0] frame_status;
  logic [15:0] read_value;
  logic last;

  slave_scoreboard sb;
  bit quiet_tail = 0;
  int watch = 0;
  logic [7:0] my_addr;
  logic [15:0] my_silence;

  modbus_rtu_register_slave_core u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(action, rx_byte, reg_index, reg_value);
      if (out_valid && !out_stall)
        sb.check_result({kind, tx_byte, frame_status, read_value, change_mark, last});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) watch = 0;
      else watch++;
      if (watch >= WATCH_LIMIT) begin
        $display("** modbus_rtu_register_slave_core: FAILED **");
        $finish;
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // valid stays up after a word so the next one can follow at once
  task automatic push_word(logic [1:0] a, logic [7:0] b, logic [3:0] i, logic [15:0] v);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; action <= a; rx_byte <= b; reg_index <= i; reg_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic push_bytes(logic [7:0] q [$]);
    foreach (q[i]) push_word(mrs_pkg::ACT_BYTE, q[i], 0, 0);
  endtask

  function automatic void seal_crc(ref logic [7:0] q [$]);
    logic [15:0] c;
    c = mrs_pkg::CRC_INIT;
    foreach (q[i]) c = sb.crc_step(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    wait_drained();
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    if (idx == mrs_pkg::CFG_SLAVE_ADDR) sb.addr_cfg = val[7:0];
    else sb.silence_cfg = val;
  endtask

  task automatic read_frame(logic [7:0] sa, int start, int cnt, bit corrupt);
    logic [7:0] q [$];
    q = {sa, mrs_pkg::FN_READ, 8'(start >> 8), 8'(start), 8'(cnt >> 8), 8'(cnt)};
    seal_crc(q);
    if (corrupt) q[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
    push_bytes(q);
  endtask

  task automatic write_frame(logic [7:0] sa, int start, int cnt, bit bad_bc, bit corrupt);
    logic [7:0] q [$];
    q = {sa, mrs_pkg::FN_WRITE, 8'(start >> 8), 8'(start), 8'(cnt >> 8), 8'(cnt)};
    q.push_back(bad_bc ? 8'(2 * cnt + 2) : 8'(2 * cnt));
    for (int i = 0; i < 2 * cnt; i++) q.push_back(8'($urandom));
    seal_crc(q);
    if (corrupt) q[$urandom_range(0, q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    push_bytes(q);
  endtask

  task automatic random_frame();
    int s, c, r;
    logic [7:0] sa;
    r = $urandom_range(0, 19);
    sa = (r == 0) ? my_addr + 8'd1 : my_addr;
    c = $urandom_range(1, 4);
    s = $urandom_range(0, NREG - c);
    if (r == 1) s = NREG - c + 1;
    if ($urandom_range(0, 1)) write_frame(sa, s, c, r == 2, r == 3);
    else read_frame(sa, s, c, r == 3);
  endtask

  task automatic random_noise();
    case ($urandom_range(0, 3))
      0: push_word(mrs_pkg::ACT_BYTE, 8'($urandom), 0, 0);
      1: repeat ($urandom_range(1, 6))
        push_word(mrs_pkg::ACT_TICK, 8'($urandom), 4'($urandom), 0);
      2: push_word(mrs_pkg::ACT_LWRITE, 8'($urandom), 4'($urandom), 16'($urandom));
      default: push_word(mrs_pkg::ACT_LREAD, 8'($urandom), 4'($urandom), 16'($urandom));
    endcase
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: default address 0, reset silence limit
    my_addr = 8'h00;
    for (int i = 0; i < 4; i++) push_word(mrs_pkg::ACT_LREAD, 0, 4'(i), 0);
    push_word(mrs_pkg::ACT_LWRITE, 0, 4'd15, 16'hFFFF);
    push_word(mrs_pkg::ACT_LWRITE, 0, 4'd0, 16'h0000);
    push_word(mrs_pkg::ACT_LREAD, 0, 4'd15, 0);
    push_word(mrs_pkg::ACT_TICK, 0, 0, 0);
    set_reg(mrs_pkg::CFG_SLAVE_ADDR, 16'h00FF);
    set_reg(mrs_pkg::CFG_SILENCE, 16'd1);
    my_addr = 8'hFF;
    write_frame(my_addr, 0, 16, 0, 0);
    read_frame(my_addr, 0, 16, 0);
    read_frame(my_addr, 15, 1, 0);
    read_frame(my_addr, 0, 0, 0);
    read_frame(8'h01, 0, 1, 0);
    read_frame(my_addr, 2, 2, 1);
    // oversize write then drop ended by a tick
    push_bytes({my_addr, mrs_pkg::FN_WRITE, 8'h00, 8'h00, 8'h00, 8'h11, 8'h22});
    push_word(mrs_pkg::ACT_TICK, 0, 0, 0);
    // partial frame timed out
    push_bytes({my_addr, mrs_pkg::FN_READ});
    push_word(mrs_pkg::ACT_TICK, 0, 0, 0);
    // unsupported function
    begin
      logic [7:0] q [$];
      q = {my_addr, 8'h06, 8'h00, 8'h01, 8'h00, 8'h01};
      seal_crc(q);
      push_bytes(q);
    end
    for (int i = 0; i < NREG; i++) push_word(mrs_pkg::ACT_LREAD, 0, 4'(i), 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      my_addr = (ph == 3) ? 8'h00 : 8'($urandom);
      my_silence = (ph == 1) ? 16'hFFFF : 16'($urandom_range(1, 5));
      set_reg(mrs_pkg::CFG_SLAVE_ADDR, {8'h00, my_addr});
      set_reg(mrs_pkg::CFG_SILENCE, my_silence);
      if (ph == 3) quiet_tail = 1;
      for (int n = 0; n < 8; n++) begin
        if ($urandom_range(0, 3) != 0) random_frame();
        else random_noise();
        if (my_silence != 16'hFFFF) repeat (my_silence) push_word(mrs_pkg::ACT_TICK, 0, 0, 0);
        else if ($urandom_range(0, 3) == 0) random_noise();
      end
      // pause until everything has come back
      wait_drained();
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** modbus_rtu_register_slave_core: PASSED **");
    else
      $display("** modbus_rtu_register_slave_core: FAILED **");
    $finish;
  end
endmodule
